>>> rtl/hsai_pkg.sv
`default_nettype none

package hsai_pkg;

    localparam int HALL_W     = 3;
    localparam int TS_W       = 32;
    localparam int ANGLE_W    = 16;
    localparam int PERIOD_W   = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_CODES  = 6;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_CODE1    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_CODE6    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_PERIOD = 3'd6;

    localparam logic [ANGLE_W-1:0] ANGLE_CODE_RST [0:NUM_CODES-1] = '{
        16'd21695, 16'd43390, 16'd32021, 16'd63834, 16'd10222, 16'd53925
    };
    localparam logic [PERIOD_W-1:0] INITIAL_PERIOD_RST = 32'd168000;

    localparam logic [HALL_W-1:0] CODE_NONE_LO = 3'd0;
    localparam logic [HALL_W-1:0] CODE_NONE_HI = 3'd7;
    localparam logic [2:0]        NO_POS       = 3'd6;
    localparam logic [2:0]        LAST_POS     = 3'd5;

    function automatic logic code_valid(input logic [HALL_W-1:0] code);
        return (code != CODE_NONE_LO) && (code != CODE_NONE_HI);
    endfunction

    // position in the forward order 5,1,3,2,6,4
    function automatic logic [2:0] seq_pos(input logic [HALL_W-1:0] code);
        logic [2:0] pos;
        case (code)
            3'd1:    pos = 3'd1;
            3'd2:    pos = 3'd3;
            3'd3:    pos = 3'd2;
            3'd4:    pos = 3'd5;
            3'd5:    pos = 3'd0;
            3'd6:    pos = 3'd4;
            default: pos = NO_POS;
        endcase
        return pos;
    endfunction

    function automatic logic reverse_step(input logic [2:0] prev, input logic [2:0] cur);
        logic back;
        if (prev == 3'd0) begin
            back = (cur == LAST_POS);
        end else begin
            back = (cur == 3'(prev - 3'd1));
        end
        return back;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hall_sector_angle_interpolator.sv
// An accepted request passes through the S_SETUP, S_DIV and S_DONE states before its
// result is loaded into the output register; the shared shift-subtract divider
// resolves one quotient bit per cycle, and a new request is taken only in S_IDLE.
// A request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) restores the register defaults and clears the
// sector state; the first request afterwards primes the block.
`default_nettype none

module hall_sector_angle_interpolator #(
    parameter int ANGLE_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_we,
    input  wire logic [hsai_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [hsai_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [2:0] hall_code, [34:3] timestamp, [39:35] zero
    input  wire logic [hsai_pkg::S_TDATA_W-1:0]       s_axis_tdata,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [15:0] angle, [16] reverse, [23:17] zero
    output logic [hsai_pkg::M_TDATA_W-1:0]            m_axis_tdata,
    // [0] sector_changed, [1] hall_invalid
    output logic [hsai_pkg::M_TUSER_W-1:0]            m_axis_tuser
);

    localparam int AW    = (ANGLE_BITS > hsai_pkg::ANGLE_W) ? ANGLE_BITS : hsai_pkg::ANGLE_W;
    localparam int DW    = TIME_BITS + 3;
    localparam int CNT_W = $clog2(ANGLE_BITS + 1);
    localparam logic [TIME_BITS-1:0] PERIOD_RST_RAW =
        hsai_pkg::INITIAL_PERIOD_RST[TIME_BITS-1:0];
    localparam logic [TIME_BITS-1:0] PERIOD_RST =
        (PERIOD_RST_RAW == '0) ? TIME_BITS'(1) : PERIOD_RST_RAW;

    hsai_pkg::t_state r_state, n_state;

    logic [hsai_pkg::ANGLE_W-1:0]  r_angle_code [0:hsai_pkg::NUM_CODES-1];
    logic [hsai_pkg::PERIOD_W-1:0] r_init_period;

    logic                          r_primed;
    logic [hsai_pkg::HALL_W-1:0]   r_prev_code;
    logic [ANGLE_BITS-1:0]         r_start_angle;
    logic                          r_reverse;
    logic [TIME_BITS-1:0]          r_start_time;
    logic [TIME_BITS-1:0]          r_period;

    logic [TIME_BITS-1:0]          r_ts;
    logic                          r_changed;
    logic                          r_invalid;

    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_div;
    logic [ANGLE_BITS-1:0]         r_quo;
    logic [CNT_W-1:0]              r_cnt;

    logic                          r_out_valid;
    logic [hsai_pkg::ANGLE_W-1:0]  r_out_angle;
    logic                          r_out_reverse;
    logic                          r_out_changed;
    logic                          r_out_invalid;

    logic [hsai_pkg::HALL_W-1:0]   w_code;
    logic [TIME_BITS-1:0]          w_ts;
    logic                          w_accept;
    logic                          w_valid;
    logic                          w_change;
    logic [2:0]                    w_code_idx;
    logic [AW-1:0]                 w_code_angle_ext;
    logic [ANGLE_BITS-1:0]         w_code_angle;
    logic [TIME_BITS-1:0]          w_meas;
    logic [TIME_BITS-1:0]          w_init_tb;
    logic [2:0]                    w_pos_cur;
    logic [2:0]                    w_pos_prev;
    logic [TIME_BITS-1:0]          w_elapsed;
    logic [TIME_BITS-1:0]          w_e;
    logic [DW:0]                   w_two;
    logic [DW:0]                   w_diff;
    logic [ANGLE_BITS-1:0]         w_angle;
    logic [AW-1:0]                 w_angle_ext;
    logic                          w_load_out;

    assign w_code   = s_axis_tdata[hsai_pkg::HALL_W-1:0];
    assign w_ts     = s_axis_tdata[hsai_pkg::HALL_W +: TIME_BITS];
    assign s_axis_tready = (r_state == hsai_pkg::S_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_valid  = hsai_pkg::code_valid(w_code);
    assign w_change = r_primed && w_valid && (w_code != r_prev_code);

    assign w_code_idx       = 3'(w_code - 3'd1);
    assign w_code_angle_ext = w_valid ? AW'(r_angle_code[w_code_idx]) : '0;
    assign w_code_angle     = w_code_angle_ext[ANGLE_BITS-1:0];

    assign w_meas    = w_ts - r_start_time;
    assign w_init_tb = r_init_period[TIME_BITS-1:0];
    assign w_pos_cur  = hsai_pkg::seq_pos(w_code);
    assign w_pos_prev = hsai_pkg::seq_pos(r_prev_code);

    assign w_elapsed = r_ts - r_start_time;
    assign w_e       = (w_elapsed < r_period) ? w_elapsed : r_period;

    assign w_two  = {r_rem, 1'b0};
    assign w_diff = w_two - {1'b0, r_div};

    assign w_angle     = r_reverse ? (r_start_angle - r_quo) : (r_start_angle + r_quo);
    assign w_angle_ext = AW'(w_angle);
    assign w_load_out  = (r_state == hsai_pkg::S_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hsai_pkg::S_IDLE: begin
                if (w_accept) n_state = hsai_pkg::S_SETUP;
            end
            hsai_pkg::S_SETUP: begin
                n_state = hsai_pkg::S_DIV;
            end
            hsai_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(ANGLE_BITS - 1)) n_state = hsai_pkg::S_DONE;
            end
            hsai_pkg::S_DONE: begin
                if (w_load_out) n_state = hsai_pkg::S_IDLE;
            end
            default: n_state = hsai_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsai_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < hsai_pkg::NUM_CODES; i++) begin
                r_angle_code[i] <= hsai_pkg::ANGLE_CODE_RST[i];
            end
            r_init_period <= hsai_pkg::INITIAL_PERIOD_RST;
            r_primed      <= 1'b0;
            r_prev_code   <= '0;
            r_start_angle <= '0;
            r_reverse     <= 1'b0;
            r_start_time  <= '0;
            r_period      <= PERIOD_RST;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_addr <= hsai_pkg::REG_ANGLE_CODE6) begin
                    r_angle_code[i_cfg_addr] <= i_cfg_data[hsai_pkg::ANGLE_W-1:0];
                end else if (i_cfg_addr == hsai_pkg::REG_INITIAL_PERIOD) begin
                    r_init_period <= i_cfg_data[hsai_pkg::PERIOD_W-1:0];
                end
            end

            // update sector state on the request
            if (w_accept) begin
                if (!r_primed) begin
                    r_primed      <= 1'b1;
                    r_prev_code   <= w_code;
                    r_start_angle <= w_code_angle;
                    r_start_time  <= w_ts;
                    r_period      <= (w_init_tb == '0) ? TIME_BITS'(1) : w_init_tb;
                    r_reverse     <= 1'b0;
                end else if (w_change) begin
                    r_prev_code   <= w_code;
                    r_start_angle <= w_code_angle;
                    r_start_time  <= w_ts;
                    r_period      <= (w_meas == '0) ? TIME_BITS'(1) : w_meas;
                    if (w_pos_prev != hsai_pkg::NO_POS) begin
                        r_reverse <= hsai_pkg::reverse_step(w_pos_prev, w_pos_cur);
                    end
                end
            end

            if (r_state == hsai_pkg::S_SETUP) begin
                r_cnt <= '0;
            end else if (r_state == hsai_pkg::S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ts      <= w_ts;
            r_changed <= w_change;
            r_invalid <= !w_valid;
        end

        // offset = e * 2^ANGLE_BITS / (6 * period), one quotient bit per cycle
        if (r_state == hsai_pkg::S_SETUP) begin
            r_rem <= DW'(w_e);
            r_div <= (DW'(r_period) << 2) + (DW'(r_period) << 1);
            r_quo <= '0;
        end else if (r_state == hsai_pkg::S_DIV) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[ANGLE_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_two[DW-1:0];
                r_quo <= {r_quo[ANGLE_BITS-2:0], 1'b0};
            end
        end

        if (w_load_out) begin
            r_out_angle   <= w_angle_ext[hsai_pkg::ANGLE_W-1:0];
            r_out_reverse <= r_reverse;
            r_out_changed <= r_changed;
            r_out_invalid <= r_invalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_reverse, r_out_angle};
    assign m_axis_tuser  = {r_out_invalid, r_out_changed};

endmodule

`default_nettype wire
